FILE: rtl/core/nbrb_pkg.sv
package nbrb_pkg;

  // Result kinds carried on out_item_kind.
  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SESSION     = 2'd0;
  localparam logic [1:0] CFG_PACKET      = 2'd1;
  localparam logic [1:0] CFG_GROUP_BYTES = 2'd2;

  // Reset value of the group span limit in bytes.
  localparam logic [4:0] GROUP_BYTES_RST = 5'd16;

  // Command from the sequencer to the bitmap store.
  typedef struct packed {
    logic       clr;
    logic       set;
    logic [2:0] bit_sel;
  } bm_cmd_t;

  // One result word as built by the sequencer.
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  hdr_session;
    logic [15:0] hdr_packet;
    logic [4:0]  record_length;
    logic [15:0] base_id;
    logic [7:0]  bitmap_byte;
    logic        group_done;
    logic        batch_done;
  } res_t;

endpackage

FILE: rtl/core/nbrb_bitmap.sv
module nbrb_bitmap #(
  parameter int DEPTH = 17,
  parameter int IW    = 5
) (
  input  logic            clk,
  input  nbrb_pkg::bm_cmd_t cmd,
  input  logic [IW-1:0]   set_idx,
  input  logic [IW-1:0]   rd_idx,
  output logic [7:0]      rd_data
);
  import nbrb_pkg::*;

  logic [7:0] bytes_r [DEPTH];

  // Whole-store clear at group start, single-bit set for each grouped id.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.clr) begin
        bytes_r[i] <= 8'd0;
      end else if (cmd.set && (set_idx == IW'(i))) begin
        bytes_r[i] <= bytes_r[i] | (8'd1 << cmd.bit_sel);
      end
    end
  end

  assign rd_data = bytes_r[rd_idx];

endmodule

FILE: rtl/core/nbrb_ctrl.sv
module nbrb_ctrl #(
  parameter int MAXB = 16,
  parameter int IW   = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  logic [15:0]       in_id,
  input  logic              in_end,
  output logic              idle,
  input  logic [7:0]        session,
  input  logic [15:0]       packet,
  input  logic [4:0]        group_bytes,
  input  logic              res_free,
  output logic              res_load,
  output nbrb_pkg::res_t    res,
  output nbrb_pkg::bm_cmd_t bm_cmd,
  output logic [IW-1:0]     bm_set_idx,
  output logic [IW-1:0]     bm_rd_idx,
  input  logic [7:0]        bm_rd_data
);
  import nbrb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_DIST  = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_HDR   = 3'd4;
  localparam logic [2:0] S_BYTES = 3'd5;

  localparam logic [4:0] MAXB_V = 5'(MAXB);

  logic [2:0]    state_r, state_nxt;
  logic [15:0]   id_r, id_nxt;
  logic          end_r, end_nxt;
  logic          close_r, close_nxt;
  logic          open_r, open_nxt;
  logic [15:0]   first_r, first_nxt;
  logic [15:0]   prev_r, prev_nxt;
  logic [IW-1:0] hb_r, hb_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;

  logic [15:0] sub_b;
  logic [16:0] diff;
  logic [4:0]  limit;
  logic [7:0]  span;
  logic        far;
  logic [IW-1:0] dist_byte;
  logic        last_byte;

  // Shared subtractor: id against the previous id, then against the group base.
  assign sub_b = (state_r == S_CMP) ? prev_r : first_r;
  assign diff  = {1'b0, id_r} - {1'b0, sub_b};

  assign limit     = (group_bytes > MAXB_V) ? MAXB_V : group_bytes;
  assign span      = {limit, 3'b000};
  assign far       = diff[15:0] > {8'd0, span};
  assign dist_byte = diff[IW+2:3];
  assign last_byte = (cnt_r == hb_r);

  assign idle       = (state_r == S_IDLE);
  assign bm_set_idx = dist_byte;
  assign bm_rd_idx  = cnt_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    id_nxt    = id_r;
    end_nxt   = end_r;
    close_nxt = close_r;
    open_nxt  = open_r;
    first_nxt = first_r;
    prev_nxt  = prev_r;
    hb_nxt    = hb_r;
    cnt_nxt   = cnt_r;
    bm_cmd    = '0;
    res_load  = 1'b0;
    res       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          id_nxt  = in_id;
          end_nxt = in_end;
          if (!open_r) begin
            open_nxt   = 1'b1;
            first_nxt  = in_id;
            prev_nxt   = in_id;
            hb_nxt     = '0;
            bm_cmd.clr = 1'b1;
            state_nxt  = S_END;
          end else begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        // Ids at or below the previous one are dropped.
        if (diff[16] || (diff[15:0] == 16'd0)) begin
          state_nxt = S_END;
        end else begin
          state_nxt = S_DIST;
        end
      end
      S_DIST: begin
        if (far) begin
          close_nxt = 1'b1;
          state_nxt = S_HDR;
        end else begin
          bm_cmd.set     = 1'b1;
          bm_cmd.bit_sel = diff[2:0];
          if (dist_byte > hb_r) begin
            hb_nxt = dist_byte;
          end
          prev_nxt  = id_r;
          state_nxt = S_END;
        end
      end
      S_END: begin
        state_nxt = end_r ? S_HDR : S_IDLE;
      end
      S_HDR: begin
        if (res_free) begin
          res_load          = 1'b1;
          res.item_kind     = KIND_HDR;
          res.hdr_session   = session;
          res.hdr_packet    = packet;
          res.record_length = 5'(hb_r) + 5'd3;
          res.base_id       = first_r;
          cnt_nxt           = '0;
          state_nxt         = S_BYTES;
        end
      end
      S_BYTES: begin
        if (res_free) begin
          res_load        = 1'b1;
          res.item_kind   = KIND_BYTE;
          res.bitmap_byte = bm_rd_data;
          res.group_done  = last_byte;
          res.batch_done  = last_byte && !close_r;
          if (!last_byte) begin
            cnt_nxt = cnt_r + IW'(1);
          end else if (close_r) begin
            // The closing id opens the next group.
            close_nxt  = 1'b0;
            first_nxt  = id_r;
            prev_nxt   = id_r;
            hb_nxt     = '0;
            bm_cmd.clr = 1'b1;
            state_nxt  = S_END;
          end else begin
            open_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      close_r <= 1'b0;
      open_r  <= 1'b0;
      first_r <= '0;
      prev_r  <= '0;
      hb_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      close_r <= close_nxt;
      open_r  <= open_nxt;
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
      hb_r    <= hb_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    end_r <= end_nxt;
  end

endmodule

FILE: rtl/core/nack_bitmap_record_builder_top.sv
// Channel  | Direction | Handshake          | Word
// in_      | input     | in_valid/in_stall  | missing_id, batch_end
// out_     | output    | out_valid/out_stall| one header or one bitmap byte
// cfg_     | input     | cfg_valid/cfg_ready| register index, write data
//
// An id that opens a group passes through S_END, one that extends it through
// S_CMP, S_DIST and S_END; the next id is taken once the sequencer is back in
// idle. A record leaves as one header and then its bitmap bytes through the
// single output register.
// All id arithmetic runs through one 17-bit subtractor, one step per cycle.
// rst_n is synchronous; no clearing pass, ready for ids right after reset.
// out_stall holds the output word and pauses the sequencer.
module nack_bitmap_record_builder_top #(
  parameter int MAX_GROUP_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_missing_id,
  input  logic        in_batch_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [7:0]  out_hdr_session,
  output logic [15:0] out_hdr_packet,
  output logic [4:0]  out_record_length,
  output logic [15:0] out_base_id,
  output logic [7:0]  out_bitmap_byte,
  output logic        out_group_done,
  output logic        out_batch_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import nbrb_pkg::*;

  localparam int DEPTH = MAX_GROUP_BYTES + 1;
  localparam int IW    = $clog2(DEPTH);

  logic [7:0]  session_r;
  logic [15:0] packet_r;
  logic [4:0]  group_bytes_r;

  logic          idle;
  logic          res_free;
  logic          res_load;
  res_t          res;
  res_t          out_r;
  logic          out_valid_r;
  bm_cmd_t       bm_cmd;
  logic [IW-1:0] bm_set_idx;
  logic [IW-1:0] bm_rd_idx;
  logic [7:0]    bm_rd_data;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r     <= '0;
      packet_r      <= '0;
      group_bytes_r <= GROUP_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SESSION:     session_r     <= cfg_data[7:0];
        CFG_PACKET:      packet_r      <= cfg_data;
        CFG_GROUP_BYTES: group_bytes_r <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !idle;

  nbrb_ctrl #(
    .MAXB(MAX_GROUP_BYTES),
    .IW  (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_valid && !in_stall),
    .in_id      (in_missing_id),
    .in_end     (in_batch_end),
    .idle       (idle),
    .session    (session_r),
    .packet     (packet_r),
    .group_bytes(group_bytes_r),
    .res_free   (res_free),
    .res_load   (res_load),
    .res        (res),
    .bm_cmd     (bm_cmd),
    .bm_set_idx (bm_set_idx),
    .bm_rd_idx  (bm_rd_idx),
    .bm_rd_data (bm_rd_data)
  );

  nbrb_bitmap #(
    .DEPTH(DEPTH),
    .IW   (IW)
  ) u_bitmap (
    .clk    (clk),
    .cmd    (bm_cmd),
    .set_idx(bm_set_idx),
    .rd_idx (bm_rd_idx),
    .rd_data(bm_rd_data)
  );

  // Output register: loads whenever it is empty or being drained.
  assign res_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_load) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_kind     = out_r.item_kind;
  assign out_hdr_session   = out_r.hdr_session;
  assign out_hdr_packet    = out_r.hdr_packet;
  assign out_record_length = out_r.record_length;
  assign out_base_id       = out_r.base_id;
  assign out_bitmap_byte   = out_r.bitmap_byte;
  assign out_group_done    = out_r.group_done;
  assign out_batch_done    = out_r.batch_done;

endmodule

FILE: rtl/core/nbrb_checker.sv
module nbrb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_item_kind,
  input logic [7:0]  out_bitmap_byte,
  input logic [15:0] out_base_id,
  input logic        out_group_done,
  input logic        out_batch_done
);
  import nbrb_pkg::*;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bitmap_byte) && $stable(out_base_id))
    else $error("output word changed under stall");

  // Headers never close a record or a batch.
  a_hdr_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == KIND_HDR) |-> !out_group_done && !out_batch_done)
    else $error("header word carries a done flag");

  // The end of a batch is always the last byte of a record.
  a_batch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_batch_done |-> out_group_done && (out_item_kind == KIND_BYTE))
    else $error("batch done outside a final bitmap byte");

  // An accepted id leaves the sequencer busy in the cycle after it is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

endmodule

bind nack_bitmap_record_builder_top nbrb_checker u_nbrb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_item_kind  (out_item_kind),
  .out_bitmap_byte(out_bitmap_byte),
  .out_base_id    (out_base_id),
  .out_group_done (out_group_done),
  .out_batch_done (out_batch_done)
);
